// ===== hdl/bra_pkg.sv =====
package bra_pkg;

    localparam int DATA_W = 8;
    localparam int LANES  = 4;
    localparam int PID_W  = 3;
    localparam int NEED_W = DATA_W + 1;
    localparam int WORK_W = 12;
    localparam int STAT_W = 3;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_REQUEST = 2'd1;
    localparam logic [1:0] FUNC_QUERY   = 2'd2;

    localparam logic [STAT_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXCEEDS  = 3'd1;
    localparam logic [STAT_W-1:0] ST_WAIT     = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNSAFE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_LOADED   = 3'd4;
    localparam logic [STAT_W-1:0] ST_REJECTED = 3'd5;
    localparam logic [STAT_W-1:0] ST_ORDER    = 3'd6;

    typedef logic [LANES-1:0][DATA_W-1:0] lanes_t;
    typedef logic signed [WORK_W-1:0]     work_t;
    typedef work_t [LANES-1:0]            work_vec_t;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        lanes_t           claim;
        lanes_t           hold;
        logic             done;
    } row_t;

    typedef struct packed {
        logic             wr;
        logic             add;
        logic             sub;
        logic             clr_done;
        logic [PID_W-1:0] pid;
    } cell_ctl_t;

endpackage

// ===== hdl/bra_cell.sv =====
module bra_cell #(
    parameter int RESOURCES = 4,
    parameter int IDX       = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  bra_pkg::row_t       nb_row,
    input  bra_pkg::cell_ctl_t  ctl,
    input  bra_pkg::lanes_t     claim_in,
    input  bra_pkg::lanes_t     hold_in,
    output bra_pkg::row_t       row
);

    localparam bra_pkg::row_t ROW_INIT = '{pid: bra_pkg::PID_W'(IDX), claim: '0,
                                           hold: '0, done: 1'b0};

    bra_pkg::row_t row_reg;
    bra_pkg::row_t row_next;

    always_comb
    begin
        row_next = row_reg;
        if (shift)
        begin
            row_next = nb_row;
        end
        else if (ctl.clr_done)
        begin
            row_next.done = 1'b0;
        end
        if (!shift && ctl.pid == row_reg.pid)
        begin
            if (ctl.wr)
            begin
                row_next.claim = claim_in;
                row_next.hold  = hold_in;
            end
            else if (ctl.add)
            begin
                for (int r = 0; r < bra_pkg::LANES; r++)
                    row_next.hold[r] = row_reg.hold[r] + hold_in[r];
            end
            else if (ctl.sub)
            begin
                for (int r = 0; r < bra_pkg::LANES; r++)
                    row_next.hold[r] = row_reg.hold[r] - hold_in[r];
            end
        end
        // Lanes beyond the configured resource count stay empty.
        for (int r = 0; r < bra_pkg::LANES; r++)
        begin
            if (r >= RESOURCES)
            begin
                row_next.claim[r] = '0;
                row_next.hold[r]  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= ROW_INIT;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row = row_reg;

endmodule

// ===== hdl/bra_fit.sv =====
module bra_fit #(
    parameter int RESOURCES = 4
) (
    input  bra_pkg::row_t      head,
    input  bra_pkg::work_vec_t work,
    output logic               fit,
    output bra_pkg::work_vec_t work_add
);

    logic signed [bra_pkg::NEED_W-1:0] need;
    logic                              ok;

    always_comb
    begin
        ok   = !head.done;
        need = '0;
        for (int r = 0; r < bra_pkg::LANES; r++)
        begin
            need = $signed({1'b0, head.claim[r]}) - $signed({1'b0, head.hold[r]});
            if (r < RESOURCES &&
                $signed({{(bra_pkg::WORK_W-bra_pkg::NEED_W){need[bra_pkg::NEED_W-1]}}, need})
                > work[r])
                ok = 1'b0;
            work_add[r] = work[r] + $signed({{(bra_pkg::WORK_W-bra_pkg::DATA_W){1'b0}},
                                             head.hold[r]});
        end
        fit = ok;
    end

endmodule

// ===== hdl/bankers_resource_allocator.sv =====
// Banker's algorithm allocator for up to eight processes and four resource types.
// Input channel (item_valid/item_stall) carries one item: a row load, a request
// or a safety query. Result channel (result_valid/result_stall) returns status,
// order_process, unsafe and last; last marks the final result of an item.
// The process rows live in a ring of cells that rotates one place per cycle past
// a single fit unit at the ring head, so one greedy pass visits all PROCESSES rows.
// A load goes straight to its result. A request or query first sums holdings
// over all PROCESSES rows; a request over its need or over availability answers
// without a safety check. Otherwise up to PROCESSES passes follow. A safe query
// yields PROCESSES results, one per cycle while the receiver takes them.
// One item is in work at a time; item_stall is high while it runs or while its
// results wait for the output register. The output register holds a result
// steady while result_stall is high. Reset clears all rows, the totals and the
// result valid flag; the block is ready in the first cycle after reset.
// Totals are written by cfg_write with cfg_index and cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
module bankers_resource_allocator #(
    parameter int PROCESSES = 8,
    parameter int RESOURCES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  func,
    input  logic [2:0]  process,
    input  logic [7:0]  amount_0,
    input  logic [7:0]  amount_1,
    input  logic [7:0]  amount_2,
    input  logic [7:0]  amount_3,
    input  logic [7:0]  claim_0,
    input  logic [7:0]  claim_1,
    input  logic [7:0]  claim_2,
    input  logic [7:0]  claim_3,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [2:0]  order_process,
    output logic        unsafe,
    output logic        last
);

    localparam int CNT_W   = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int FOUND_W = $clog2(PROCESSES + 1);
    localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(PROCESSES - 1);
    localparam logic [FOUND_W-1:0] FOUND_ALL = FOUND_W'(PROCESSES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SUM    = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]                 state_reg, state_next;
    bra_pkg::lanes_t            total_reg, total_next;
    logic [1:0]                 func_reg, func_next;
    logic [2:0]                 proc_reg, proc_next;
    bra_pkg::lanes_t            amt_reg, amt_next;
    bra_pkg::work_vec_t         work_reg, work_next;
    logic signed [bra_pkg::NEED_W-1:0] need_reg [bra_pkg::LANES];
    logic signed [bra_pkg::NEED_W-1:0] need_next [bra_pkg::LANES];
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [FOUND_W-1:0]         found_reg, found_next;
    logic                       moved_reg, moved_next;
    logic [2:0]                 ord_reg [PROCESSES];
    logic [2:0]                 ord_next [PROCESSES];
    logic [2:0]                 st_reg, st_next;
    logic                       multi_reg, multi_next;
    logic                       uns_reg, uns_next;
    logic                       rv_reg, rv_next;
    logic [2:0]                 status_reg, status_next;
    logic [2:0]                 op_reg, op_next;
    logic                       unsafe_reg, unsafe_next;
    logic                       last_reg, last_next;

    bra_pkg::row_t              rows [PROCESSES];
    bra_pkg::row_t              head_moved;
    bra_pkg::cell_ctl_t         ctl;
    bra_pkg::lanes_t            amt_in, clm_in, hold_data;
    bra_pkg::work_vec_t         work_add;
    logic                       fit, fit_eff, shift, accept, load_ok;
    logic                       over_need, over_avail, out_free, pass_end;
    logic [FOUND_W-1:0]         found_inc;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign shift      = (state_reg == S_SUM) || (state_reg == S_CHECK);
    assign fit_eff    = fit && (state_reg == S_CHECK);
    assign out_free   = !rv_reg || !result_stall;
    assign pass_end   = (cnt_reg == CNT_LAST);
    assign found_inc  = found_reg + FOUND_W'(fit_eff);

    always_comb
    begin
        amt_in = {amount_3, amount_2, amount_1, amount_0};
        clm_in = {claim_3, claim_2, claim_1, claim_0};
        for (int r = 0; r < bra_pkg::LANES; r++)
        begin
            if (r >= RESOURCES)
            begin
                amt_in[r] = '0;
                clm_in[r] = '0;
            end
        end
        load_ok = ({1'b0, process} < 4'(PROCESSES));
        for (int r = 0; r < bra_pkg::LANES; r++)
            if (amt_in[r] > clm_in[r])
                load_ok = 1'b0;
        over_need  = 1'b0;
        over_avail = 1'b0;
        for (int r = 0; r < bra_pkg::LANES; r++)
        begin
            if ($signed({1'b0, amt_reg[r]}) > need_reg[r])
                over_need = 1'b1;
            if ($signed({4'b0, amt_reg[r]}) > work_reg[r])
                over_avail = 1'b1;
        end
    end

    // The head row re-enters at the tail, marked done when it fit this cycle.
    always_comb
    begin
        head_moved      = rows[0];
        head_moved.done = rows[0].done || fit_eff;
    end

    always_comb
    begin
        hold_data    = accept ? amt_in : amt_reg;
        ctl.wr       = accept && (func == bra_pkg::FUNC_LOAD) && load_ok;
        ctl.add      = (state_reg == S_DECIDE) && (func_reg == bra_pkg::FUNC_REQUEST) &&
                       !over_need && !over_avail;
        ctl.sub      = (state_reg == S_FINISH) && (func_reg == bra_pkg::FUNC_REQUEST) &&
                       (found_reg != FOUND_ALL);
        ctl.clr_done = accept;
        ctl.pid      = accept ? process : proc_reg;
    end

    genvar g;
    generate
        for (g = 0; g < PROCESSES; g++)
        begin : g_cell
            bra_cell #(
                .RESOURCES(RESOURCES),
                .IDX(g)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .shift(shift),
                .nb_row((g == PROCESSES - 1) ? head_moved : rows[(g + 1) % PROCESSES]),
                .ctl(ctl),
                .claim_in(clm_in),
                .hold_in(hold_data),
                .row(rows[g])
            );
        end
    endgenerate

    bra_fit #(
        .RESOURCES(RESOURCES)
    ) u_fit (
        .head(rows[0]),
        .work(work_reg),
        .fit(fit),
        .work_add(work_add)
    );

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        func_next   = func_reg;
        proc_next   = proc_reg;
        amt_next    = amt_reg;
        work_next   = work_reg;
        need_next   = need_reg;
        cnt_next    = cnt_reg;
        found_next  = found_reg;
        moved_next  = moved_reg;
        ord_next    = ord_reg;
        st_next     = st_reg;
        multi_next  = multi_reg;
        uns_next    = uns_reg;
        rv_next     = rv_reg && result_stall;
        status_next = status_reg;
        op_next     = op_reg;
        unsafe_next = unsafe_reg;
        last_next   = last_reg;

        if (cfg_write)
            total_next[cfg_index] = cfg_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    proc_next  = process;
                    amt_next   = amt_in;
                    multi_next = 1'b0;
                    uns_next   = 1'b0;
                    cnt_next   = '0;
                    for (int r = 0; r < bra_pkg::LANES; r++)
                        work_next[r] = $signed({4'b0, (r < RESOURCES) ? total_reg[r] : 8'd0});
                    case (func)
                        bra_pkg::FUNC_LOAD:
                        begin
                            st_next    = load_ok ? bra_pkg::ST_LOADED : bra_pkg::ST_REJECTED;
                            state_next = S_EMIT;
                        end
                        bra_pkg::FUNC_REQUEST:
                        begin
                            if ({1'b0, process} < 4'(PROCESSES))
                                state_next = S_SUM;
                            else
                            begin
                                st_next    = bra_pkg::ST_EXCEEDS;
                                state_next = S_EMIT;
                            end
                        end
                        bra_pkg::FUNC_QUERY:
                        begin
                            state_next = S_SUM;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SUM:
            begin
                for (int r = 0; r < bra_pkg::LANES; r++)
                begin
                    work_next[r] = work_reg[r] - $signed({4'b0, rows[0].hold[r]});
                    if (rows[0].pid == proc_reg)
                        need_next[r] = $signed({1'b0, rows[0].claim[r]}) -
                                       $signed({1'b0, rows[0].hold[r]});
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (pass_end)
                begin
                    cnt_next   = '0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                found_next = '0;
                moved_next = 1'b0;
                cnt_next   = '0;
                state_next = S_CHECK;
                if (func_reg == bra_pkg::FUNC_REQUEST)
                begin
                    if (over_need)
                    begin
                        st_next    = bra_pkg::ST_EXCEEDS;
                        state_next = S_EMIT;
                    end
                    else if (over_avail)
                    begin
                        st_next    = bra_pkg::ST_WAIT;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        for (int r = 0; r < bra_pkg::LANES; r++)
                            work_next[r] = work_reg[r] - $signed({4'b0, amt_reg[r]});
                    end
                end
            end
            S_CHECK:
            begin
                if (fit_eff)
                begin
                    work_next  = work_add;
                    moved_next = 1'b1;
                    found_next = found_inc;
                    for (int i = 0; i < PROCESSES - 1; i++)
                        ord_next[i] = ord_reg[i + 1];
                    ord_next[PROCESSES - 1] = rows[0].pid;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (pass_end)
                begin
                    cnt_next   = '0;
                    moved_next = 1'b0;
                    if (found_inc == FOUND_ALL || !(moved_reg || fit_eff))
                        state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_EMIT;
                cnt_next   = '0;
                if (func_reg == bra_pkg::FUNC_REQUEST)
                    st_next = (found_reg == FOUND_ALL) ? bra_pkg::ST_GRANTED
                                                       : bra_pkg::ST_UNSAFE;
                else if (found_reg == FOUND_ALL)
                begin
                    st_next    = bra_pkg::ST_ORDER;
                    multi_next = 1'b1;
                end
                else
                begin
                    st_next  = bra_pkg::ST_UNSAFE;
                    uns_next = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    rv_next     = 1'b1;
                    status_next = st_reg;
                    unsafe_next = uns_reg;
                    if (multi_reg)
                    begin
                        op_next   = ord_reg[0];
                        last_next = pass_end;
                        for (int i = 0; i < PROCESSES - 1; i++)
                            ord_next[i] = ord_reg[i + 1];
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (pass_end)
                            state_next = S_IDLE;
                    end
                    else
                    begin
                        op_next    = '0;
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        proc_reg   <= proc_next;
        amt_reg    <= amt_next;
        work_reg   <= work_next;
        need_reg   <= need_next;
        cnt_reg    <= cnt_next;
        found_reg  <= found_next;
        moved_reg  <= moved_next;
        ord_reg    <= ord_next;
        st_reg     <= st_next;
        multi_reg  <= multi_next;
        uns_reg    <= uns_next;
        status_reg <= status_next;
        op_reg     <= op_next;
        unsafe_reg <= unsafe_next;
        last_reg   <= last_next;
    end

    assign result_valid  = rv_reg;
    assign status        = status_reg;
    assign order_process = op_reg;
    assign unsafe        = unsafe_reg;
    assign last          = last_reg;

    // Between items the ring is back in place, with process 0 at the head.
    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (rows[0].pid == 3'd0))
        else $error("ring not aligned while idle");

    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (found_reg <= FOUND_ALL))
        else $error("more processes finished than exist");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && status_reg != bra_pkg::ST_ORDER) |-> (last_reg && op_reg == 3'd0))
        else $error("single result without last");

    a_unsafe_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && unsafe_reg) |-> (status_reg == bra_pkg::ST_UNSAFE))
        else $error("unsafe flag on wrong status");

endmodule
